@@ rtl/rai_pkg.sv @@
// ----------------------------------------------------------------------------
// rai_pkg
// Shared types and constants for the register ALU instruction executor.
// ----------------------------------------------------------------------------
package rai_pkg;

    localparam int DEF_NUM_REGS = 16;
    localparam int Q_DEPTH      = 2;

    // opcodes
    localparam logic [7:0] OP_SET  = 8'd0;
    localparam logic [7:0] OP_ADD  = 8'd16;
    localparam logic [7:0] OP_ADDI = 8'd17;
    localparam logic [7:0] OP_SUB  = 8'd32;
    localparam logic [7:0] OP_SUBI = 8'd33;
    localparam logic [7:0] OP_MUL  = 8'd48;
    localparam logic [7:0] OP_MULI = 8'd49;
    localparam logic [7:0] OP_DIV  = 8'd64;
    localparam logic [7:0] OP_DIVI = 8'd65;

    // cycle weights
    localparam logic [2:0] WT_NONE = 3'd0;
    localparam logic [2:0] WT_ALU  = 3'd1;
    localparam logic [2:0] WT_MUL  = 3'd2;
    localparam logic [2:0] WT_DIV  = 3'd4;

    typedef enum logic [2:0] {
        K_SET,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BADOP = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_DONE
    } t_state;

    // classified instruction as held in the queue
    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] left;
        logic [7:0] right;
        t_kind      kind;
        logic       imm;
        t_status    status;
        logic [2:0] weight;
    } t_instr;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/rai_decode.sv @@
// ----------------------------------------------------------------------------
// rai_decode
// Front end: classifies an incoming instruction, checks opcode and register
// ranges and assigns its cycle weight before it enters the queue.
// ----------------------------------------------------------------------------
module rai_decode #(
    parameter int NUM_REGS = rai_pkg::DEF_NUM_REGS
) (
    input  logic [7:0]      i_func,
    input  logic [7:0]      i_dest_index,
    input  logic [7:0]      i_left_byte,
    input  logic [7:0]      i_right_byte,
    output rai_pkg::t_instr o_instr
);
    import rai_pkg::*;

    logic  w_known;
    logic  w_imm;
    logic  w_d_bad;
    logic  w_l_bad;
    logic  w_r_bad;
    t_kind w_kind;
    logic [2:0] w_weight;

    assign w_imm   = i_func[0];
    assign w_d_bad = 32'(i_dest_index) >= 32'(NUM_REGS);
    assign w_l_bad = 32'(i_left_byte) >= 32'(NUM_REGS);
    assign w_r_bad = 32'(i_right_byte) >= 32'(NUM_REGS);

    always_comb begin
        w_known  = 1'b1;
        w_kind   = K_SET;
        w_weight = WT_ALU;
        unique case (i_func) inside
            OP_SET: begin
                w_kind = K_SET;
            end
            OP_ADD, OP_ADDI: begin
                w_kind = K_ADD;
            end
            OP_SUB, OP_SUBI: begin
                w_kind = K_SUB;
            end
            OP_MUL, OP_MULI: begin
                w_kind   = K_MUL;
                w_weight = WT_MUL;
            end
            OP_DIV, OP_DIVI: begin
                w_kind   = K_DIV;
                w_weight = WT_DIV;
            end
            default: begin
                w_known  = 1'b0;
                w_weight = WT_NONE;
            end
        endcase
    end

    always_comb begin
        o_instr.dest   = i_dest_index;
        o_instr.left   = i_left_byte;
        o_instr.right  = i_right_byte;
        o_instr.kind   = w_kind;
        o_instr.imm    = w_imm;
        o_instr.weight = w_weight;
        if (!w_known) begin
            o_instr.status = ST_BADOP;
        end else if (w_d_bad) begin
            o_instr.status = ST_RANGE;
        end else if (w_kind == K_SET) begin
            o_instr.status = ST_OK;
        end else if (w_l_bad || (!w_imm && w_r_bad)) begin
            o_instr.status = ST_RANGE;
        end else begin
            o_instr.status = ST_OK;
        end
    end

endmodule

@@ rtl/rai_queue.sv @@
// ----------------------------------------------------------------------------
// rai_queue
// Short FIFO of classified instructions between the front and back ends.
// ----------------------------------------------------------------------------
module rai_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rai_pkg::t_instr i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output rai_pkg::t_instr o_head
);
    import rai_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_instr          r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ rtl/rai_div.sv @@
// ----------------------------------------------------------------------------
// rai_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero when started.
// ----------------------------------------------------------------------------
module rai_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rai_pkg::t_div_req i_req,
    output rai_pkg::t_div_rsp o_rsp
);
    import rai_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [32:0] w_rem_sh;
    logic [32:0] w_diff;
    logic [31:0] w_mag_a;
    logic [31:0] w_mag_b;

    assign w_mag_a  = i_req.dividend[31] ? 32'd0 - i_req.dividend : i_req.dividend;
    assign w_mag_b  = i_req.divisor[31] ? 32'd0 - i_req.divisor : i_req.divisor;
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? 32'd0 - r_quo : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring step: remainder never exceeds the divisor, so 32 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

endmodule

@@ rtl/rai_exec.sv @@
// ----------------------------------------------------------------------------
// rai_exec
// Back end: reads operands from the register file, runs the ALU or the
// divider, writes back and presents the result in an output register.
// ----------------------------------------------------------------------------
module rai_exec #(
    parameter int NUM_REGS = rai_pkg::DEF_NUM_REGS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  rai_pkg::t_instr    i_head,
    output logic               o_pop,
    output rai_pkg::t_div_req  o_div_req,
    input  rai_pkg::t_div_rsp  i_div_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_target_index,
    output logic [31:0]        o_written_value,
    output logic               o_wrote,
    output rai_pkg::t_status   o_status,
    output logic [31:0]        o_total_cycles,
    output logic [31:0]        o_instructions_seen
);
    import rai_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    t_state        r_state;
    t_state        n_state;
    t_instr        r_cur;
    logic [31:0]   r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic          r_a_vld;
    logic          r_b_vld;
    logic [31:0]   r_res;
    logic          r_wrote;
    t_status       r_stat;
    logic [31:0]   r_tally;
    logic [31:0]   r_count;
    logic          r_out_vld;
    logic [7:0]    r_out_tgt;
    logic [31:0]   r_out_val;
    logic          r_out_wrote;
    t_status       r_out_stat;
    logic [31:0]   r_out_total;
    logic [31:0]   r_out_seen;
    logic [31:0]   n_tally;

    logic          w_calc_load;
    logic          w_div_load;
    logic          w_out_load;
    logic          w_out_free;
    logic [31:0]   w_a;
    logic [31:0]   w_b;
    logic [31:0]   w_prod;
    logic [31:0]   w_calc_res;
    logic          w_calc_wrote;
    t_status       w_calc_stat;
    logic          w_to_div;

    assign w_out_free = !r_out_vld || i_ready;
    assign w_a    = r_a_vld ? r_rd_a : 32'd0;
    assign w_b    = r_cur.imm ? {24'd0, r_cur.right} : (r_b_vld ? r_rd_b : 32'd0);
    assign w_prod = w_a * w_b;

    // alu result for set, add, sub and mul, and the divide-by-zero check
    always_comb begin
        w_calc_res   = 32'd0;
        w_calc_wrote = 1'b0;
        w_calc_stat  = r_cur.status;
        w_to_div     = 1'b0;
        if (r_cur.status == ST_OK) begin
            case (r_cur.kind)
                K_SET: begin
                    w_calc_res   = {24'd0, r_cur.left};
                    w_calc_wrote = 1'b1;
                end
                K_ADD: begin
                    w_calc_res   = w_a + w_b;
                    w_calc_wrote = 1'b1;
                end
                K_SUB: begin
                    w_calc_res   = w_a - w_b;
                    w_calc_wrote = 1'b1;
                end
                K_MUL: begin
                    w_calc_res   = w_prod;
                    w_calc_wrote = 1'b1;
                end
                K_DIV: begin
                    if (w_b == 32'd0) begin
                        w_calc_stat = ST_DIVZ;
                    end else begin
                        w_to_div = 1'b1;
                    end
                end
                default: begin
                    w_calc_stat = ST_BADOP;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = w_to_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_pop              = 1'b0;
        w_calc_load        = 1'b0;
        w_div_load         = 1'b0;
        w_out_load         = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = w_a;
        o_div_req.divisor  = w_b;
        unique case (r_state)
            S_IDLE: begin
                o_pop = !i_q_empty;
            end
            S_CALC: begin
                w_calc_load     = 1'b1;
                o_div_req.start = w_to_div;
            end
            S_DIV: begin
                w_div_load = i_div_rsp.done;
            end
            S_DONE: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign n_tally            = r_tally + 32'(r_cur.weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_tally   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_tally   <= n_tally;
                r_count   <= r_count + 32'd1;
                r_out_vld <= 1'b1;
                if (r_wrote) begin
                    r_vld[r_cur.dest[AW-1:0]] <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // register file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_a  <= r_mem[i_head.left[AW-1:0]];
            r_rd_b  <= r_mem[i_head.right[AW-1:0]];
            r_a_vld <= r_vld[i_head.left[AW-1:0]];
            r_b_vld <= r_vld[i_head.right[AW-1:0]];
        end
        if (w_out_load && r_wrote) begin
            r_mem[r_cur.dest[AW-1:0]] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (w_calc_load) begin
            r_res   <= w_calc_res;
            r_wrote <= w_calc_wrote;
            r_stat  <= w_calc_stat;
        end else if (w_div_load) begin
            r_res   <= i_div_rsp.quotient;
            r_wrote <= 1'b1;
            r_stat  <= ST_OK;
        end
        if (w_out_load) begin
            r_out_tgt   <= r_cur.dest;
            r_out_val   <= r_wrote ? r_res : 32'd0;
            r_out_wrote <= r_wrote;
            r_out_stat  <= r_stat;
            r_out_total <= n_tally + 32'd1;
            r_out_seen  <= r_count + 32'd1;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_target_index      = r_out_tgt;
    assign o_written_value     = r_out_val;
    assign o_wrote             = r_out_wrote;
    assign o_status            = r_out_stat;
    assign o_total_cycles      = r_out_total;
    assign o_instructions_seen = r_out_seen;

endmodule

@@ rtl/register_alu_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// register_alu_instruction_executor
// Executes 4-byte register ALU instructions against a register file.
// ----------------------------------------------------------------------------
// Instructions come in on the s_axis channel, one request per 32-bit word:
// opcode, destination index, left byte, right byte from the low byte up.
// Each one gives exactly one result on m_axis: the echoed destination, the
// value written, the write flag and status in tuser, the cycle tally plus
// one and the instruction count.
// The front end classifies a request and puts it into a two-entry queue;
// s_axis_tready is low only while that queue is full. The back end takes one
// instruction at a time: register read, execute, write back.
// Divides run through the 32 steps of the radix-2 divider, except when they
// fault; set, add, sub and mul are done by the ALU. The back end pops the
// next instruction only once the last result has been loaded into the
// output register.
// Reset clears the register file (through per-register valid bits), the
// counters and the queue. When the receiver holds m_axis_tready low, the
// result stays in the output register, the back end waits with the next
// result and the queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor #(
    parameter int NUM_REGS = rai_pkg::DEF_NUM_REGS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[7:0], dest_index[15:8], left_byte[23:16], right_byte[31:24]
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // target_index[7:0], written_value[39:8], total_cycles[71:40],
    // instructions_seen[103:72]
    output logic [103:0] m_axis_tdata,
    // wrote[0], status[2:1]
    output logic [2:0]   m_axis_tuser
);
    import rai_pkg::*;

    t_instr   w_dec;
    t_instr   w_head;
    logic     w_full;
    logic     w_empty;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic [7:0]  w_tgt;
    logic [31:0] w_val;
    logic        w_wrote;
    t_status     w_stat;
    logic [31:0] w_total;
    logic [31:0] w_seen;

    assign s_axis_tready = !w_full;

    rai_decode #(
        .NUM_REGS (NUM_REGS)
    ) u_decode (
        .i_func       (s_axis_tdata[7:0]),
        .i_dest_index (s_axis_tdata[15:8]),
        .i_left_byte  (s_axis_tdata[23:16]),
        .i_right_byte (s_axis_tdata[31:24]),
        .o_instr      (w_dec)
    );

    rai_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_entry (w_dec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    rai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rai_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (w_empty),
        .i_head              (w_head),
        .o_pop               (w_pop),
        .o_div_req           (w_div_req),
        .i_div_rsp           (w_div_rsp),
        .o_valid             (m_axis_tvalid),
        .i_ready             (m_axis_tready),
        .o_target_index      (w_tgt),
        .o_written_value     (w_val),
        .o_wrote             (w_wrote),
        .o_status            (w_stat),
        .o_total_cycles      (w_total),
        .o_instructions_seen (w_seen)
    );

    assign m_axis_tdata = {w_seen, w_total, w_val, w_tgt};
    assign m_axis_tuser = {w_stat, w_wrote};

endmodule

@@ dv/register_alu_instruction_executor_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_alu_instruction_executor_test
// Self-checking bench for the register ALU instruction executor: a shadow
// register file predicts every result, random gaps on both streams.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor_test;
    import rai_pkg::*;

    localparam int          REGS        = DEF_NUM_REGS;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          RANDOM_REQS = 1625;

    typedef struct packed {
        logic [7:0]  target;
        logic [31:0] value;
        logic        wrote;
        t_status     status;
        logic [31:0] cycles;
        logic [31:0] seen;
    } t_alu_result;

    typedef struct packed {
        logic        drain_first;
        logic [31:0] word;
    } t_instr_entry;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // func[7:0], dest_index[15:8], left_byte[23:16], right_byte[31:24]
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // target_index[7:0], written_value[39:8], total_cycles[71:40],
    // instructions_seen[103:72]
    logic [103:0] m_axis_tdata;
    // wrote[0], status[2:1]
    logic [2:0]   m_axis_tuser;

    t_instr_entry instr_queue[$];
    t_alu_result  pending_results[$];
    logic [31:0]  shadow_regs[REGS];
    logic [31:0]  shadow_tally;
    logic [31:0]  shadow_count;
    int unsigned  fail_count;
    int unsigned  cycle_count;
    int unsigned  gap_left;
    int unsigned  stall_left;
    logic         quiet_phase;
    logic         req_taken;

    register_alu_instruction_executor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the register file: applies one instruction, returns its result
    function automatic t_alu_result run_instruction(logic [31:0] word);
        logic [7:0]  op;
        logic [7:0]  dst;
        logic [7:0]  lft;
        logic [7:0]  rgt;
        logic [7:0]  base;
        logic        imm;
        logic        known;
        logic [2:0]  weight;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quot;
        t_alu_result res;
        op     = word[7:0];
        dst    = word[15:8];
        lft    = word[23:16];
        rgt    = word[31:24];
        base   = {op[7:1], 1'b0};
        imm    = op[0];
        known  = 1'b1;
        weight = WT_NONE;
        if (op == OP_SET) begin
            weight = WT_ALU;
        end else if (op >= OP_ADD && op <= OP_DIVI) begin
            if (base == OP_ADD || base == OP_SUB) weight = WT_ALU;
            else if (base == OP_MUL) weight = WT_MUL;
            else if (base == OP_DIV) weight = WT_DIV;
            else known = 1'b0;
        end else begin
            known = 1'b0;
        end
        res        = '0;
        res.target = dst;
        res.status = ST_OK;
        shadow_count = shadow_count + 1;
        if (!known) begin
            res.status = ST_BADOP;
        end else begin
            // faulting but known opcodes still add their weight
            shadow_tally = shadow_tally + 32'(weight);
            if (dst >= REGS) begin
                res.status = ST_RANGE;
            end else if (op == OP_SET) begin
                res.value = {24'd0, lft};
                res.wrote = 1'b1;
            end else if (lft >= REGS || (!imm && rgt >= REGS)) begin
                res.status = ST_RANGE;
            end else begin
                a = shadow_regs[lft];
                b = imm ? {24'd0, rgt} : shadow_regs[rgt];
                case (base)
                    OP_ADD: begin
                        res.value = a + b;
                        res.wrote = 1'b1;
                    end
                    OP_SUB: begin
                        res.value = a - b;
                        res.wrote = 1'b1;
                    end
                    OP_MUL: begin
                        res.value = a * b;
                        res.wrote = 1'b1;
                    end
                    OP_DIV: begin
                        if (b == 32'd0) begin
                            res.status = ST_DIVZ;
                        end else begin
                            // truncate toward zero on magnitudes, min / -1 wraps
                            mag_a     = a[31] ? -a : a;
                            mag_b     = b[31] ? -b : b;
                            quot      = mag_a / mag_b;
                            res.value = (a[31] ^ b[31]) ? -quot : quot;
                            res.wrote = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (res.wrote) shadow_regs[dst] = res.value;
        res.cycles = shadow_tally + 1;
        res.seen   = shadow_count;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_failure(string msg);
        if (fail_count < 10) $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            flag_failure($sformatf("%s mismatch: expected %0h, got %0h", field, want, got));
    endtask

    task automatic push_instr(logic [7:0] op, logic [7:0] dst, logic [7:0] lft,
                              logic [7:0] rgt, logic drain);
        t_instr_entry ent;
        ent.drain_first = drain;
        ent.word        = {rgt, lft, dst, op};
        instr_queue.push_back(ent);
    endtask

    function automatic logic [7:0] pick_known_op();
        case ($urandom_range(0, 8))
            0: return OP_SET;
            1: return OP_ADD;
            2: return OP_ADDI;
            3: return OP_SUB;
            4: return OP_SUBI;
            5: return OP_MUL;
            6: return OP_MULI;
            7: return OP_DIV;
            default: return OP_DIVI;
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin
        logic        drive_valid;
        logic [31:0] drive_word;
        drive_valid = s_axis_tvalid;
        drive_word  = s_axis_tdata;
        if (i_rst_n) begin
            if (s_axis_tvalid && !req_taken) begin
                drive_valid = 1'b1;
            end else if (gap_left > 0) begin
                drive_valid = 1'b0;
                gap_left <= gap_left - 1;
            end else if (instr_queue.size() > 0 &&
                         !(instr_queue[0].drain_first && pending_results.size() > 0)) begin
                drive_word  = instr_queue[0].word;
                drive_valid = 1'b1;
                instr_queue.pop_front();
                gap_left <= pick_gap();
                if ($urandom_range(0, 149) == 0) quiet_phase <= !quiet_phase;
            end else begin
                drive_valid = 1'b0;
            end
        end
        s_axis_tvalid <= drive_valid;
        s_axis_tdata  <= drive_word;
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_alu_result want;
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(run_instruction(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_failure($sformatf("unexpected result: tdata %0h tuser %0h",
                                       m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                compare_field("target_index", 32'(want.target), 32'(m_axis_tdata[7:0]));
                compare_field("written_value", want.value, m_axis_tdata[39:8]);
                compare_field("wrote", 32'(want.wrote), 32'(m_axis_tuser[0]));
                compare_field("status", 32'(want.status), 32'(m_axis_tuser[2:1]));
                compare_field("total_cycles", want.cycles, m_axis_tdata[71:40]);
                compare_field("instructions_seen", want.seen, m_axis_tdata[103:72]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] op;
        logic [7:0] dst;
        logic [7:0] lft;
        logic [7:0] rgt;
        int unsigned roll;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        req_taken     = 1'b0;
        gap_left      = 0;
        stall_left    = 0;
        quiet_phase   = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        shadow_tally  = '0;
        shadow_count  = '0;
        for (int i = 0; i < REGS; i++) shadow_regs[i] = '0;

        // directed: build extreme values, then hit every fault path
        push_instr(OP_SET,  8'd0,   8'd255, 8'd0,   1'b0);
        push_instr(OP_SET,  8'd3,   8'd1,   8'd255, 1'b0);
        push_instr(OP_SUB,  8'd4,   8'd1,   8'd3,   1'b0);  // r4 = -1
        push_instr(OP_SET,  8'd5,   8'd128, 8'd0,   1'b0);
        push_instr(OP_MUL,  8'd6,   8'd5,   8'd5,   1'b0);
        push_instr(OP_MUL,  8'd6,   8'd6,   8'd6,   1'b0);
        push_instr(OP_MULI, 8'd6,   8'd6,   8'd8,   1'b0);  // r6 = most negative
        push_instr(OP_DIV,  8'd7,   8'd6,   8'd4,   1'b0);  // overflow wraps
        push_instr(OP_DIVI, 8'd8,   8'd6,   8'd7,   1'b0);
        push_instr(OP_DIV,  8'd9,   8'd4,   8'd0,   1'b0);
        push_instr(OP_DIV,  8'd9,   8'd0,   8'd1,   1'b0);  // divide by zero register
        push_instr(OP_DIVI, 8'd9,   8'd0,   8'd0,   1'b0);  // divide by zero immediate
        push_instr(OP_ADDI, 8'd10,  8'd0,   8'd255, 1'b0);
        push_instr(OP_SUBI, 8'd11,  8'd1,   8'd255, 1'b0);
        push_instr(OP_SUB,  8'd15,  8'd6,   8'd3,   1'b0);
        push_instr(OP_ADD,  8'd12,  8'd0,   8'd4,   1'b0);
        push_instr(OP_SET,  8'd255, 8'd7,   8'd0,   1'b0);
        push_instr(OP_ADD,  8'd3,   8'd16,  8'd2,   1'b0);
        push_instr(OP_ADD,  8'd3,   8'd2,   8'd16,  1'b0);
        push_instr(OP_DIVI, 8'd20,  8'd2,   8'd0,   1'b0);  // range wins over div zero
        push_instr(OP_DIV,  8'd15,  8'd255, 8'd1,   1'b0);
        push_instr(8'd1,    8'd2,   8'd3,   8'd4,   1'b0);
        push_instr(8'd18,   8'd2,   8'd3,   8'd4,   1'b0);
        push_instr(8'd66,   8'd2,   8'd3,   8'd4,   1'b0);
        push_instr(8'd255,  8'd255, 8'd255, 8'd255, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            roll = $urandom_range(0, 99);
            op   = pick_known_op();
            dst  = 8'($urandom_range(0, REGS - 1));
            lft  = (op == OP_SET) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, REGS - 1));
            rgt  = op[0] ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, REGS - 1));
            if (op[0] && $urandom_range(0, 19) == 0) rgt = 8'd0;
            if (roll >= 85) begin
                dst = 8'($urandom_range(0, 255));
                lft = 8'($urandom_range(0, 255));
                rgt = 8'($urandom_range(0, 255));
            end
            if (roll >= 95) op = 8'($urandom_range(0, 255));
            push_instr(op, dst, lft, rgt, (i == 600 || i == 1200));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
